### rtl/core/sgi_pkg.sv
// Shared types for the 2D segment intersection pipeline.
// No dependencies.
package sgi_pkg;

  typedef enum logic {
    MODE_RAY = 1'b0,
    MODE_SEG = 1'b1
  } mode_t;

endpackage

### rtl/core/sgi_divider.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Depends on sgi_pkg.
module sgi_divider #(
  parameter int NUM_WIDTH = 68,
  parameter int DEN_WIDTH = 35,
  parameter int Q_WIDTH   = 17,
  parameter int TAG_WIDTH = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [NUM_WIDTH-1:0] num,
  input  logic signed [DEN_WIDTH-1:0] den,
  input  logic        [TAG_WIDTH-1:0] in_tag,
  output logic                        out_valid,
  output logic signed [Q_WIDTH-1:0]   quo,
  output logic        [TAG_WIDTH-1:0] out_tag
);
  import sgi_pkg::*;

  localparam int RW = DEN_WIDTH + 1;

  // Quotient magnitude fits in Q_WIDTH bits, so only Q_WIDTH steps are needed.
  logic                 v   [Q_WIDTH+1];
  logic [RW-1:0]        rem [Q_WIDTH+1];
  logic [Q_WIDTH-1:0]   q   [Q_WIDTH+1];
  logic [DEN_WIDTH-1:0] d   [Q_WIDTH+1];
  logic [NUM_WIDTH-1:0] n   [Q_WIDTH+1];
  logic                 neg [Q_WIDTH+1];
  logic [TAG_WIDTH-1:0] tag [Q_WIDTH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
    n[0]   <= num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
    d[0]   <= den[DEN_WIDTH-1] ? DEN_WIDTH'(-den) : DEN_WIDTH'(den);
    neg[0] <= num[NUM_WIDTH-1] ^ den[DEN_WIDTH-1];
    tag[0] <= in_tag;
    rem[0] <= '0;
    q[0]   <= '0;
  end

  for (genvar i = 0; i < Q_WIDTH; i++) begin : g_step
    localparam int B = Q_WIDTH - 1 - i;
    logic [RW-1:0] trial;
    logic [RW:0]   diff;
    always_comb begin
      if (i == 0) begin
        trial = RW'(n[i] >> B);
      end else begin
        trial = {rem[i][RW-2:0], n[i][B]};
      end
      diff = {1'b0, trial} - {2'b00, d[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v[i];
      end
      rem[i+1] <= diff[RW] ? trial : diff[RW-1:0];
      q[i+1]   <= {q[i][Q_WIDTH-2:0], ~diff[RW]};
      d[i+1]   <= d[i];
      n[i+1]   <= n[i];
      neg[i+1] <= neg[i];
      tag[i+1] <= tag[i];
    end
  end

  assign out_valid = v[Q_WIDTH];
  assign quo       = neg[Q_WIDTH] ? Q_WIDTH'(-q[Q_WIDTH]) : Q_WIDTH'(q[Q_WIDTH]);
  assign out_tag   = tag[Q_WIDTH];
endmodule

### rtl/core/sgi_front.sv
// Front stages: differences, cross products, range checks and point numerators.
// Depends on sgi_pkg.
module sgi_front #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  sgi_pkg::mode_t        mode,
  input  logic signed [W-1:0]   a_x0,
  input  logic signed [W-1:0]   a_y0,
  input  logic signed [W-1:0]   a_x1,
  input  logic signed [W-1:0]   a_y1,
  input  logic signed [W-1:0]   b_x0,
  input  logic signed [W-1:0]   b_y0,
  input  logic signed [W-1:0]   b_x1,
  input  logic signed [W-1:0]   b_y1,
  output logic                  out_valid,
  output logic                  hit,
  output logic                  seg,
  output logic signed [W-1:0]   ax,
  output logic signed [W-1:0]   ay,
  output logic signed [3*W+3:0] nx,
  output logic signed [3*W+3:0] ny,
  output logic signed [2*W+2:0] den
);
  import sgi_pkg::*;

  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int CW = 2 * W + 3;
  localparam int NW = 3 * W + 4;

  // stage 1: differences
  logic                 v1, seg1;
  logic signed [DW-1:0] dx1, dy1, ex1, ey1, rx1, ry1;
  logic signed [W-1:0]  ax1, ay1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    seg1 <= (mode == MODE_SEG);
    dx1 <= (mode == MODE_SEG) ? DW'(a_x1) - DW'(a_x0) : DW'(a_x1);
    dy1 <= (mode == MODE_SEG) ? DW'(a_y1) - DW'(a_y0) : DW'(a_y1);
    ex1 <= DW'(b_x1) - DW'(b_x0);
    ey1 <= DW'(b_y1) - DW'(b_y0);
    rx1 <= DW'(a_x0) - DW'(b_x0);
    ry1 <= DW'(a_y0) - DW'(b_y0);
    ax1 <= a_x0;
    ay1 <= a_y0;
  end

  // stage 2: products
  logic                 v2, seg2;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [DW-1:0] dx2, dy2;
  logic signed [W-1:0]  ax2, ay2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    seg2 <= seg1;
    p0 <= dx1 * ey1;
    p1 <= dy1 * ex1;
    p2 <= dx1 * ry1;
    p3 <= dy1 * rx1;
    p4 <= ex1 * ry1;
    p5 <= ey1 * rx1;
    dx2 <= dx1;
    dy2 <= dy1;
    ax2 <= ax1;
    ay2 <= ay1;
  end

  // stage 3: cross products
  logic                 v3, seg3;
  logic signed [CW-1:0] den3, sn3, tn3;
  logic signed [DW-1:0] dx3, dy3;
  logic signed [W-1:0]  ax3, ay3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    seg3 <= seg2;
    den3 <= CW'(p0) - CW'(p1);
    sn3  <= CW'(p2) - CW'(p3);
    tn3  <= CW'(p4) - CW'(p5);
    dx3 <= dx2;
    dy3 <= dy2;
    ax3 <= ax2;
    ay3 <= ay2;
  end

  function automatic logic in_unit(logic signed [CW-1:0] nm, logic signed [CW-1:0] dn);
    if (dn < 0) begin
      return (nm >= dn) && (nm <= 0);
    end
    return (nm >= 0) && (nm <= dn);
  endfunction

  logic s_ok, t_ok, t_pos, hit3;
  always_comb begin
    s_ok  = (den3 != 0) && in_unit(sn3, den3);
    t_ok  = in_unit(tn3, den3);
    t_pos = (tn3 == 0) || (tn3[CW-1] == den3[CW-1]);
    hit3  = s_ok && (seg3 ? t_ok : t_pos);
  end

  // stage 4: point numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v3;
    end
    hit <= hit3;
    seg <= seg3;
    nx  <= NW'(dx3) * NW'(tn3);
    ny  <= NW'(dy3) * NW'(tn3);
    den <= den3;
    ax  <= ax3;
    ay  <= ay3;
  end
endmodule

### rtl/core/segment_intersection_2d.sv
// Top level of the 2D ray/segment and segment/segment intersection pipeline.
// Depends on sgi_pkg, sgi_front and sgi_divider.
//
// Takes one query per cycle; busy is always low. Each result appears with
// done high for one cycle, in order, and is taken at the edge that ends that
// cycle. The stages are four front stages (differences, products, cross
// products and range checks, point numerators), the divider input register,
// COORD_WIDTH+2 one-bit divider stages and an output register. The receiver
// cannot stall, so there is no backpressure.
module segment_intersection_2d #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  sgi_pkg::mode_t                mode,
  input  logic signed [COORD_WIDTH-1:0] a_x0,
  input  logic signed [COORD_WIDTH-1:0] a_y0,
  input  logic signed [COORD_WIDTH-1:0] a_x1,
  input  logic signed [COORD_WIDTH-1:0] a_y1,
  input  logic signed [COORD_WIDTH-1:0] b_x0,
  input  logic signed [COORD_WIDTH-1:0] b_y0,
  input  logic signed [COORD_WIDTH-1:0] b_x1,
  input  logic signed [COORD_WIDTH-1:0] b_y1,
  output logic                          done,
  output logic                          hit,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y
);
  import sgi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int NW = 3 * W + 4;
  localparam int DN = 2 * W + 3;
  localparam int QW = W + 2;
  localparam int TW = W + 2;

  logic                 f_valid, f_hit, f_seg;
  logic signed [W-1:0]  f_ax, f_ay;
  logic signed [NW-1:0] f_nx, f_ny;
  logic signed [DN-1:0] f_den;

  assign busy = 1'b0;

  sgi_front #(.W(W)) u_front (
    .clk, .rst,
    .in_valid(start),
    .mode, .a_x0, .a_y0, .a_x1, .a_y1, .b_x0, .b_y0, .b_x1, .b_y1,
    .out_valid(f_valid),
    .hit(f_hit),
    .seg(f_seg),
    .ax(f_ax),
    .ay(f_ay),
    .nx(f_nx),
    .ny(f_ny),
    .den(f_den)
  );

  // Zero numerators keep the dividers defined when the word is not a segment-mode hit.
  logic          use_pt;
  logic [TW-1:0] tag_in, tag_x, tag_y;
  logic          vx, vy;
  logic signed [QW-1:0] qx, qy;
  logic signed [DN-1:0] den_safe;

  assign use_pt   = f_hit && f_seg;
  assign den_safe = use_pt ? f_den : DN'(1);
  assign tag_in   = {use_pt, f_hit, f_ax};

  sgi_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(DN), .Q_WIDTH(QW), .TAG_WIDTH(TW)) u_div_x (
    .clk, .rst,
    .in_valid(f_valid),
    .num(use_pt ? f_nx : NW'(0)),
    .den(den_safe),
    .in_tag(tag_in),
    .out_valid(vx),
    .quo(qx),
    .out_tag(tag_x)
  );

  sgi_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(DN), .Q_WIDTH(QW), .TAG_WIDTH(TW)) u_div_y (
    .clk, .rst,
    .in_valid(f_valid),
    .num(use_pt ? f_ny : NW'(0)),
    .den(den_safe),
    .in_tag({2'b00, f_ay}),
    .out_valid(vy),
    .quo(qy),
    .out_tag(tag_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vx && vy;
    end
    hit     <= tag_x[W];
    point_x <= tag_x[W+1] ? W'(tag_x[W-1:0]) + W'(qx) : '0;
    point_y <= tag_x[W+1] ? W'(tag_y[W-1:0]) + W'(qy) : '0;
  end
endmodule
